>>> src/blie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blie_pkg: shared types and constants for the bounded list insert engine
// Sizes, request and status codes, and the command passed from the front
// queue to the back end.
// ----------------------------------------------------------------------------
package blie_pkg;

    // List sizing
    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int FILL_W   = 4;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_PREPEND = 2'd1,
        REQ_SORTED  = 2'd2,
        REQ_READ    = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

    // Classified command from the front queue
    typedef struct packed {
        req_t              req;
        logic              is_read;
        logic [VAL_W-1:0]  value;
    } cmd_t;

endpackage

>>> src/blie_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blie_front: input acceptance and command queue
// Decodes each accepted item into a command and holds it in a two-entry
// queue so up to two items can wait while the back end is busy.
// ----------------------------------------------------------------------------
module blie_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  in_req,
    input  logic [blie_pkg::VAL_W-1:0]  in_value,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output blie_pkg::cmd_t              cmd
);

    blie_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;
    blie_pkg::cmd_t in_cmd;

    // Classify the request
    always_comb begin
        in_cmd.req     = blie_pkg::req_t'(in_req);
        in_cmd.is_read = (blie_pkg::req_t'(in_req) == blie_pkg::REQ_READ);
        in_cmd.value   = in_value;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = cmd_valid & cmd_ready;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> src/blie_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blie_back: list storage and command execution
// Holds the entry cells and count. Inserts compare and shift all cells in parallel;
// read-out streams one entry per cycle through the output register while it is taken.
// ----------------------------------------------------------------------------
module blie_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  blie_pkg::cmd_t               cmd,
    output logic                         out_valid,
    input  logic                         out_ready,
    output blie_pkg::status_t            out_status,
    output logic [blie_pkg::VAL_W-1:0]   out_element,
    output logic [blie_pkg::FILL_W-1:0]  out_fill,
    output logic                         out_last
);

    logic [blie_pkg::VAL_W-1:0]  ent_reg [blie_pkg::CAPACITY];
    logic [blie_pkg::VAL_W-1:0]  ent_next [blie_pkg::CAPACITY];
    logic [blie_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [blie_pkg::IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    blie_pkg::back_state_t       state_reg, state_next;

    logic                        ov_reg, ov_next;
    blie_pkg::status_t           st_reg, st_next;
    logic [blie_pkg::VAL_W-1:0]  el_reg, el_next;
    logic [blie_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic                        last_reg, last_next;

    logic                        slot_free;
    logic                        take;
    logic                        full;
    logic                        do_insert;
    logic [blie_pkg::CAPACITY-1:0] lt;
    logic [blie_pkg::CNT_W-1:0]  sort_pos;
    logic [blie_pkg::CNT_W-1:0]  pos;
    logic                        found;

    assign slot_free = !ov_reg || out_ready;
    assign cmd_ready = (state_reg == blie_pkg::BK_IDLE) && slot_free;
    assign take      = cmd_valid && cmd_ready;
    assign full      = (count_reg == blie_pkg::CNT_W'(blie_pkg::CAPACITY));
    assign do_insert = take && !cmd.is_read && !full;

    // Per-cell signed compare against the new value
    always_comb begin
        for (int i = 0; i < blie_pkg::CAPACITY; i++) begin
            lt[i] = ($signed(ent_reg[i]) < $signed(cmd.value));
        end
    end

    // First held entry that is not smaller than the value
    always_comb begin
        sort_pos = count_reg;
        found    = 1'b0;
        for (int i = 0; i < blie_pkg::CAPACITY; i++) begin
            if (!found && (blie_pkg::CNT_W'(i) < count_reg) && !lt[i]) begin
                sort_pos = blie_pkg::CNT_W'(i);
                found    = 1'b1;
            end
        end
    end

    // Insert position by request kind
    always_comb begin
        case (cmd.req)
            blie_pkg::REQ_APPEND:  pos = count_reg;
            blie_pkg::REQ_PREPEND: pos = '0;
            blie_pkg::REQ_SORTED:  pos = sort_pos;
            default:               pos = count_reg;
        endcase
    end

    // Cell shift network: keep below pos, write at pos, shift up above
    always_comb begin
        for (int j = 0; j < blie_pkg::CAPACITY; j++) begin
            if (blie_pkg::CNT_W'(j) < pos) begin
                ent_next[j] = ent_reg[j];
            end else if (blie_pkg::CNT_W'(j) == pos) begin
                ent_next[j] = cmd.value;
            end else begin
                ent_next[j] = ent_reg[(j > 0) ? j - 1 : 0];
            end
        end
    end

    // Sequencer and output register loading
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        ov_next     = ov_reg && !out_ready;
        st_next     = st_reg;
        el_next     = el_reg;
        fill_next   = fill_reg;
        last_next   = last_reg;
        case (state_reg)
            blie_pkg::BK_IDLE: begin
                if (take) begin
                    if (cmd.is_read) begin
                        if (count_reg == '0) begin
                            ov_next   = 1'b1;
                            st_next   = blie_pkg::ST_EMPTY;
                            el_next   = '0;
                            fill_next = '0;
                            last_next = 1'b1;
                        end else begin
                            rd_idx_next = '0;
                            state_next  = blie_pkg::BK_READ;
                        end
                    end else if (full) begin
                        ov_next   = 1'b1;
                        st_next   = blie_pkg::ST_FULL;
                        el_next   = '0;
                        fill_next = blie_pkg::FILL_W'(count_reg);
                        last_next = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                        ov_next    = 1'b1;
                        st_next    = blie_pkg::ST_OK;
                        el_next    = '0;
                        fill_next  = blie_pkg::FILL_W'(count_reg + 1'b1);
                        last_next  = 1'b1;
                    end
                end
            end
            blie_pkg::BK_READ: begin
                if (slot_free) begin
                    ov_next     = 1'b1;
                    st_next     = blie_pkg::ST_OK;
                    el_next     = ent_reg[rd_idx_reg];
                    fill_next   = blie_pkg::FILL_W'(count_reg);
                    last_next   = (blie_pkg::CNT_W'(rd_idx_reg) + 1'b1 == count_reg);
                    rd_idx_next = rd_idx_reg + 1'b1;
                    if (blie_pkg::CNT_W'(rd_idx_reg) + 1'b1 == count_reg) begin
                        state_next = blie_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = blie_pkg::BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= blie_pkg::BK_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            ov_reg     <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        st_reg   <= st_next;
        el_reg   <= el_next;
        fill_reg <= fill_next;
        last_reg <= last_next;
        if (do_insert) begin
            for (int j = 0; j < blie_pkg::CAPACITY; j++) begin
                ent_reg[j] <= ent_next[j];
            end
        end
    end

    assign out_valid   = ov_reg;
    assign out_status  = st_reg;
    assign out_element = el_reg;
    assign out_fill    = fill_reg;
    assign out_last    = last_reg;

endmodule

>>> src/bounded_list_insert_engine_core.sv
`timescale 1ns / 1ps
// An insert result passes the front queue, then the back end output register.
// Read-out: one entry per cycle while the receiver takes them.
// One insert per cycle while results are taken; a read-out holds the back end
// until its last entry is loaded; the queue holds up to two items meanwhile.
// Reset: synchronous, active low; clears the count, queue and output valid.
// Entry cells are not cleared; only held positions are ever read.
// ----------------------------------------------------------------------------
// bounded_list_insert_engine_core: bounded sorted-insertion list
// Front queue feeding a parallel compare-and-shift list with streamed read-out.
// ----------------------------------------------------------------------------
module bounded_list_insert_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] element, [35:32] fill, [39:36] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    logic                          cmd_valid;
    logic                          cmd_ready;
    blie_pkg::cmd_t                cmd;
    blie_pkg::status_t             status;
    logic [blie_pkg::VAL_W-1:0]    element;
    logic [blie_pkg::FILL_W-1:0]   fill;

    // Front: accept and queue
    blie_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_value  (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: list cells and result stream
    blie_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (status),
        .out_element (element),
        .out_fill    (fill),
        .out_last    (m_tlast)
    );

    assign m_tdata = {4'd0, fill, element};
    assign m_tuser = status;

endmodule

>>> src/blie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blie_checker: port-level checks for the bounded list insert engine
// Watches the result stream for handshake stability and status consistency.
// ----------------------------------------------------------------------------
module blie_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Stalled item holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // Empty read-out is a single zero item
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == blie_pkg::ST_EMPTY) |->
            m_tlast && (m_tdata == 40'd0))
        else $error("empty status with bad payload");

    // Rejected insert reports a full list
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == blie_pkg::ST_FULL) |->
            m_tlast && (m_tdata[31:0] == 32'd0)
            && (m_tdata[35:32] == 4'(blie_pkg::CAPACITY)))
        else $error("full status with bad payload");

    // Fill never exceeds capacity, and a non-final item has entries
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[35:32] <= 4'(blie_pkg::CAPACITY))
                     && (m_tlast || (m_tdata[35:32] != 4'd0)))
        else $error("fill out of range");

endmodule

bind bounded_list_insert_engine_core blie_checker u_blie_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bounded_list_insert_engine_core
// Runs a table of directed requests that fills the list through the
// extremes, equal values and the full case, then a random mix of inserts and
// read-outs. A software copy of the list predicts every result. Both stream
// sides idle at random, and one long receiver stall backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS   = 95;
    localparam int LONG_HOLD      = 100;
    localparam int WATCHDOG_LIMIT = 1500;
    localparam int DRAIN_CYCLES   = 8;

    // One expected result item
    typedef struct {
        blie_pkg::status_t          status;
        logic [blie_pkg::VAL_W-1:0] element;
        logic [3:0]                 fill;
        logic                       last;
    } list_result_t;

    // One row of the directed table; typed rows carry their own expectation
    typedef struct {
        blie_pkg::req_t             req;
        logic [blie_pkg::VAL_W-1:0] value;
        bit                         typed;
        blie_pkg::status_t          t_status;
        logic [3:0]                 t_fill;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic [1:0]  s_tuser;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] element, [35:32] fill, [39:36] zero
    logic [1:0]  m_tuser;   // [1:0] status
    logic        m_tlast;

    // Software copy of the list
    logic [blie_pkg::VAL_W-1:0] list_entries [blie_pkg::CAPACITY];
    int                         list_count;

    list_result_t pending_results [$];
    int           mismatch_count;
    bit           long_hold_req;

    // Fills the list to capacity, then hits the full case on every insert kind
    directed_row_t directed_rows [15] = '{
        '{blie_pkg::REQ_READ,    32'h0000_0000, 1'b1, blie_pkg::ST_EMPTY, 4'd0},
        '{blie_pkg::REQ_SORTED,  32'h0000_0005, 1'b1, blie_pkg::ST_OK,    4'd1},
        '{blie_pkg::REQ_SORTED,  32'h8000_0000, 1'b1, blie_pkg::ST_OK,    4'd2},
        '{blie_pkg::REQ_SORTED,  32'h7FFF_FFFF, 1'b1, blie_pkg::ST_OK,    4'd3},
        '{blie_pkg::REQ_SORTED,  32'h0000_0005, 1'b0, blie_pkg::ST_OK,    4'd0},
        '{blie_pkg::REQ_SORTED,  32'hFFFF_FFFF, 1'b0, blie_pkg::ST_OK,    4'd0},
        '{blie_pkg::REQ_READ,    32'h0000_0000, 1'b0, blie_pkg::ST_OK,    4'd0},
        '{blie_pkg::REQ_APPEND,  32'h0000_0000, 1'b0, blie_pkg::ST_OK,    4'd0},
        '{blie_pkg::REQ_PREPEND, 32'h5555_5555, 1'b0, blie_pkg::ST_OK,    4'd0},
        '{blie_pkg::REQ_SORTED,  32'hAAAA_AAAA, 1'b1, blie_pkg::ST_OK,    4'd8},
        '{blie_pkg::REQ_READ,    32'h0000_0000, 1'b0, blie_pkg::ST_OK,    4'd0},
        '{blie_pkg::REQ_APPEND,  32'h0000_0001, 1'b1, blie_pkg::ST_FULL,  4'd8},
        '{blie_pkg::REQ_PREPEND, 32'hFFFF_FFFF, 1'b1, blie_pkg::ST_FULL,  4'd8},
        '{blie_pkg::REQ_SORTED,  32'h0000_0000, 1'b1, blie_pkg::ST_FULL,  4'd8},
        '{blie_pkg::REQ_READ,    32'h0000_0000, 1'b0, blie_pkg::ST_OK,    4'd0}
    };

    bounded_list_insert_engine_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Idle length: mostly short, sometimes long
    function automatic int pick_idle();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random value with the extremes mixed in
    function automatic logic [blie_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Apply one request to the list copy and queue the results it causes
    function automatic void predict_list_step(input blie_pkg::req_t req,
                                              input logic [blie_pkg::VAL_W-1:0] value);
        list_result_t r;
        int pos;
        if (req == blie_pkg::REQ_READ) begin
            if (list_count == 0) begin
                r = '{blie_pkg::ST_EMPTY, '0, 4'd0, 1'b1};
                pending_results.push_back(r);
            end else begin
                for (int i = 0; i < list_count; i++) begin
                    r = '{blie_pkg::ST_OK, list_entries[i], 4'(list_count),
                          (i == list_count - 1)};
                    pending_results.push_back(r);
                end
            end
            return;
        end
        if (list_count >= blie_pkg::CAPACITY) begin
            r = '{blie_pkg::ST_FULL, '0, 4'(list_count), 1'b1};
            pending_results.push_back(r);
            return;
        end
        case (req)
            blie_pkg::REQ_APPEND:  pos = list_count;
            blie_pkg::REQ_PREPEND: pos = 0;
            default: begin
                // first entry not smaller than the value, signed
                pos = 0;
                while (pos < list_count &&
                       $signed(list_entries[pos]) < $signed(value))
                    pos++;
            end
        endcase
        for (int j = list_count; j > pos; j--)
            list_entries[j] = list_entries[j-1];
        list_entries[pos] = value;
        list_count++;
        r = '{blie_pkg::ST_OK, '0, 4'(list_count), 1'b1};
        pending_results.push_back(r);
    endfunction

    // Offer one item from a falling edge; returns at the falling edge after
    // it is taken. A typed expectation replaces the predicted one.
    task automatic send_request(input blie_pkg::req_t req,
                                input logic [blie_pkg::VAL_W-1:0] value,
                                input int idle, input bit typed,
                                input list_result_t typed_res);
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        if (typed) begin
            predict_list_step(req, value);
            void'(pending_results.pop_back());
            pending_results.push_back(typed_res);
        end else begin
            predict_list_step(req, value);
        end
        @(negedge aclk);
    endtask

    // Sender pauses until every expected item has come out
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Receiver: random ready pattern, plus one long hold on request
    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_idle()) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin : result_check
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 40'(m_tuser), 40'(want.status));
                if (m_tdata[31:0] !== want.element)
                    report_mismatch("element", 40'(m_tdata[31:0]), 40'(want.element));
                if (m_tdata[35:32] !== want.fill)
                    report_mismatch("fill", 40'(m_tdata[35:32]), 40'(want.fill));
                if (m_tlast !== want.last)
                    report_mismatch("last", 40'(m_tlast), 40'(want.last));
                if (m_tdata[39:36] !== 4'd0)
                    report_mismatch("tdata padding", 40'(m_tdata[39:36]), 40'd0);
            end
        end
    end

    // Watchdog: too long with no item moving on either side
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Stimulus
    initial begin
        list_result_t typed_res;
        int idle;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = blie_pkg::REQ_APPEND;
        mismatch_count = 0;
        list_count     = 0;
        long_hold_req  = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table
        foreach (directed_rows[k]) begin
            typed_res = '{directed_rows[k].t_status, '0, directed_rows[k].t_fill, 1'b1};
            idle = ($urandom_range(0, 1) == 0) ? 0 : pick_idle();
            send_request(directed_rows[k].req, directed_rows[k].value, idle,
                         directed_rows[k].typed, typed_res);
        end
        wait_results_drained();

        // Random mix; a back-to-back burst runs against the long hold
        typed_res = '{blie_pkg::ST_OK, '0, 4'd0, 1'b0};
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 30)
                long_hold_req = 1'b1;
            if (n == 80)
                wait_results_drained();
            if (n >= 30 && n < 60)
                idle = 0;
            else
                idle = ($urandom_range(0, 1) == 0) ? 0 : pick_idle();
            send_request(blie_pkg::req_t'($urandom_range(0, 3)), pick_value(), idle,
                         1'b0, typed_res);
        end
        s_tvalid <= 1'b0;

        // Wait out the tail, then a drain wait for anything stray
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
